// ----- src/imush_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, tables and types of the IMU scaling and heading block.
package imush_pkg;

    // Number of CORDIC vectoring steps, one pipeline stage each (12 to 32).
    localparam int CORDIC_STEPS = 20;

    // Scaling lane: pre-factor product, gain product and saturate stages.
    localparam int LANE_STAGES   = 3;
    localparam int CORDIC_STAGES = CORDIC_STEPS + 2;
    localparam int PIPE_STAGES   = LANE_STAGES + CORDIC_STAGES;
    localparam int NUM_LANES     = 9;

    localparam int RAW_W    = 16;
    localparam int FACTOR_W = 9;
    localparam int GAIN_W   = 32;
    localparam int OUT_W    = 32;
    localparam int P1_W     = 25;
    localparam int P2_W     = 57;

    // CORDIC datapath widths: x/y carry growth, angle in Q8.24 degrees.
    localparam int XW = 36;
    localparam int ZW = 35;
    localparam int QW = ZW - 8;
    localparam int HEAD_W = 25;

    localparam logic [ZW-1:0] Z_HALF_TURN = ZW'(180) << 24;
    localparam logic [HEAD_W-1:0] HEAD_WRAP = HEAD_W'(360) << 16;

    localparam logic [ZW-1:0] ATAN_TAB [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_ADJ_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_ADJ_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_ADJ_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_GAIN   = 3'd5;

    // Stage enables of the heading pipeline.
    typedef struct packed {
        logic                    prep;
        logic [CORDIC_STEPS-1:0] step;
        logic                    fin;
    } cordic_en_t;

    typedef logic [NUM_LANES-1:0][OUT_W-1:0] axis_vec_t;

endpackage

// ----- src/imush_scale_lane.sv -----
`timescale 1ns / 1ps
// One scaling lane: raw axis times pre-factor times gain, shifted and saturated.
module imush_scale_lane (
    input  logic                             clk,
    input  logic [imush_pkg::LANE_STAGES-1:0] en,
    input  logic signed [imush_pkg::RAW_W-1:0] raw,
    input  logic [imush_pkg::FACTOR_W-1:0]   factor,
    input  logic [imush_pkg::GAIN_W-1:0]     gain,
    output logic signed [imush_pkg::OUT_W-1:0] result
);
    import imush_pkg::*;

    logic signed [P1_W-1:0] p1_reg;
    logic signed [P2_W-1:0] p2_reg;
    logic signed [OUT_W-1:0] out_reg;

    logic signed [P1_W:0]   p1_full;
    logic signed [P2_W:0]   p2_full;
    logic [P2_W-17:0]       shifted;
    logic [OUT_W-1:0]       sat_val;

    assign p1_full = raw * $signed({1'b0, factor});
    assign p2_full = p1_reg * $signed({1'b0, gain});

    // The floor shift by 16 is a plain bit select of the product.
    assign shifted = p2_reg[P2_W-1:16];

    always_comb
    begin
        if ((&shifted[P2_W-17:OUT_W-1]) || !(|shifted[P2_W-17:OUT_W-1]))
        begin
            sat_val = shifted[OUT_W-1:0];
        end
        else if (shifted[P2_W-17])
        begin
            sat_val = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_reg <= $signed(p1_full[P1_W-1:0]);
        end
        if (en[1])
        begin
            p2_reg <= $signed(p2_full[P2_W-1:0]);
        end
        if (en[2])
        begin
            out_reg <= $signed(sat_val);
        end
    end

    assign result = out_reg;

endmodule

// ----- src/imush_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC that turns the magnetometer x/y pair into a heading.
module imush_cordic (
    input  logic                               clk,
    input  imush_pkg::cordic_en_t              en,
    input  logic signed [imush_pkg::OUT_W-1:0] mag_x,
    input  logic signed [imush_pkg::OUT_W-1:0] mag_y,
    output logic [imush_pkg::HEAD_W-1:0]       heading
);
    import imush_pkg::*;

    logic signed [XW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic [HEAD_W-1:0]    head_reg;

    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [ZW-1:0] zr;
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] q_wrap;
    logic signed [QW-1:0] wrap_s;

    // The vector starts in the right half plane; the left half folds over by 180 degrees.
    assign px = {{(XW-OUT_W){mag_y[OUT_W-1]}}, mag_y};
    assign py = {{(XW-OUT_W){mag_x[OUT_W-1]}}, mag_x};

    always_ff @(posedge clk)
    begin
        if (en.prep)
        begin
            zero_reg[0] <= (mag_x == '0) && (mag_y == '0);
            if (px[XW-1])
            begin
                x_reg[0] <= -px;
                y_reg[0] <= -py;
                z_reg[0] <= $signed(Z_HALF_TURN);
            end
            else
            begin
                x_reg[0] <= px;
                y_reg[0] <= py;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en.step[CORDIC_STEPS-1-k])
            begin
                zero_reg[k+1] <= zero_reg[k];
                if (y_reg[k][XW-1])
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - $signed(ATAN_TAB[k % 32]);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + $signed(ATAN_TAB[k % 32]);
                end
            end
        end
    end

    // Round Q8.24 to Q16 by adding half an LSB and dropping eight bits, then wrap.
    assign zr     = z_reg[CORDIC_STEPS] + $signed(ZW'(128));
    assign q      = $signed(zr[ZW-1:8]);
    assign wrap_s = $signed({{(QW-HEAD_W){1'b0}}, HEAD_WRAP});

    always_comb
    begin
        priority if (q < 0)
        begin
            q_wrap = q + wrap_s;
        end
        else if (q >= wrap_s)
        begin
            q_wrap = q - wrap_s;
        end
        else
        begin
            q_wrap = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.fin)
        begin
            head_reg <= zero_reg[CORDIC_STEPS] ? '0 : q_wrap[HEAD_W-1:0];
        end
    end

    assign heading = head_reg;

endmodule

// ----- src/imu_sample_scaling_and_heading_top.sv -----
`timescale 1ns / 1ps
// Top level of the IMU sample scaling and compass heading block.
// Stages: three lane stages, a fold stage, one stage per CORDIC step and a round/wrap
// stage that is also the output register.
// Throughput: one frame per cycle while m_tready is high; every stage holds its own valid
// bit, so bubbles close up and a new frame enters while a finished result waits for
// m_tready, as long as some stage is empty.
// Reset clears all valid bits and returns the configuration registers to their defaults.
module imu_sample_scaling_and_heading_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input frame, from bit 0: accel_bytes[47:0], gyro_bytes[47:0], mag_bytes[47:0].
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [143:0]                      s_tdata,
    // Result, from bit 0: accel_x/y/z_out, gyro_x/y/z_out, mag_x/y/z_out (32 bits each),
    // heading_deg[24:0], then seven zero bits.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [319:0]                      m_tdata,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [imush_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data
);
    import imush_pkg::*;

    // Configuration registers.
    logic [7:0]  mag_adj_x_reg;
    logic [7:0]  mag_adj_y_reg;
    logic [7:0]  mag_adj_z_reg;
    logic [31:0] accel_gain_reg;
    logic [31:0] gyro_gain_reg;
    logic [31:0] mag_gain_reg;

    // Per-stage valid bits and the enable chain that moves words forward.
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] stage_en;

    logic [47:0] accel_bytes;
    logic [47:0] gyro_bytes;
    logic [47:0] mag_bytes;

    logic signed [RAW_W-1:0] lane_raw    [NUM_LANES];
    logic [FACTOR_W-1:0]     lane_factor [NUM_LANES];
    logic [GAIN_W-1:0]       lane_gain   [NUM_LANES];
    axis_vec_t               lane_out;

    // Scaled axes ride along beside the CORDIC so they leave with their heading.
    axis_vec_t               side_reg [0:CORDIC_STAGES-1];
    cordic_en_t              cordic_en;
    logic [HEAD_W-1:0]       heading;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_adj_x_reg  <= 8'd128;
            mag_adj_y_reg  <= 8'd128;
            mag_adj_z_reg  <= 8'd128;
            accel_gain_reg <= 32'd262144;
            gyro_gain_reg  <= 32'd32786009;
            mag_gain_reg   <= 32'd2516582;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAG_ADJ_X:  mag_adj_x_reg  <= cfg_data[7:0];
                REG_MAG_ADJ_Y:  mag_adj_y_reg  <= cfg_data[7:0];
                REG_MAG_ADJ_Z:  mag_adj_z_reg  <= cfg_data[7:0];
                REG_ACCEL_GAIN: accel_gain_reg <= cfg_data;
                REG_GYRO_GAIN:  gyro_gain_reg  <= cfg_data;
                REG_MAG_GAIN:   mag_gain_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb
    begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign accel_bytes = s_tdata[47:0];
    assign gyro_bytes  = s_tdata[95:48];
    assign mag_bytes   = s_tdata[143:96];

    // Accelerometer and gyroscope pairs are high byte first, magnetometer pairs low
    // byte first. Only the magnetometer lanes use a sensitivity pre-factor.
    always_comb
    begin
        lane_raw[0] = $signed(accel_bytes[47:32]);
        lane_raw[1] = $signed(accel_bytes[31:16]);
        lane_raw[2] = $signed(accel_bytes[15:0]);
        lane_raw[3] = $signed(gyro_bytes[47:32]);
        lane_raw[4] = $signed(gyro_bytes[31:16]);
        lane_raw[5] = $signed(gyro_bytes[15:0]);
        lane_raw[6] = $signed({mag_bytes[39:32], mag_bytes[47:40]});
        lane_raw[7] = $signed({mag_bytes[23:16], mag_bytes[31:24]});
        lane_raw[8] = $signed({mag_bytes[7:0], mag_bytes[15:8]});
        for (int i = 0; i < 6; i++)
        begin
            lane_factor[i] = FACTOR_W'(1);
        end
        lane_factor[6] = {1'b0, mag_adj_x_reg} + FACTOR_W'(128);
        lane_factor[7] = {1'b0, mag_adj_y_reg} + FACTOR_W'(128);
        lane_factor[8] = {1'b0, mag_adj_z_reg} + FACTOR_W'(128);
        for (int i = 0; i < 3; i++)
        begin
            lane_gain[i]   = accel_gain_reg;
            lane_gain[i+3] = gyro_gain_reg;
            lane_gain[i+6] = mag_gain_reg;
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        imush_scale_lane u_lane (
            .clk    (clk),
            .en     (stage_en[LANE_STAGES-1:0]),
            .raw    (lane_raw[l]),
            .factor (lane_factor[l]),
            .gain   (lane_gain[l]),
            .result (lane_out[l])
        );
    end

    // Map the flat enable chain onto the heading pipeline; step 0 is the upper bit.
    always_comb
    begin
        cordic_en.prep = stage_en[LANE_STAGES];
        cordic_en.fin  = stage_en[PIPE_STAGES-1];
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            cordic_en.step[CORDIC_STEPS-1-k] = stage_en[LANE_STAGES+1+k];
        end
    end

    imush_cordic u_cordic (
        .clk     (clk),
        .en      (cordic_en),
        .mag_x   (lane_out[6]),
        .mag_y   (lane_out[7]),
        .heading (heading)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[LANE_STAGES])
        begin
            side_reg[0] <= lane_out;
        end
        for (int i = 1; i < CORDIC_STAGES; i++)
        begin
            if (stage_en[LANE_STAGES+i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign m_tdata = {7'b0, heading, side_reg[CORDIC_STAGES-1]};

    // The input side stalls only when every stage holds a word.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg))
        else $error("input stalled with an empty pipeline stage");

    // An accepted word that is not matched by a delivered one adds one word in flight.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !(m_tvalid && m_tready))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("accepted word lost in the pipeline");

    // A delivered word with nothing accepted removes one word in flight.
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (!(s_tvalid && s_tready) && m_tvalid && m_tready)
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) - 1))
        else $error("delivered word not removed from the pipeline");

    // The wrapped heading always lies below a full turn.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[312:288] < HEAD_WRAP))
        else $error("heading outside one turn");

endmodule

// ----- sim/imu_sample_scaling_and_heading_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: IMU frame scaling and compass heading against a built-in predictor.
module imu_sample_scaling_and_heading_top_tb;

    import imush_pkg::*;

    localparam int PIPE_LATENCY  = CORDIC_STEPS + 5;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 8;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_FRAMES = 230;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_PRINTED   = 40;

    // Indexes that decode to no register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    // Arctangent of 2^-i in Q8.24 degrees.
    localparam longint ARCTAN_Q24 [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [143:0]   s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [319:0]   m_tdata;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]    cfg_data = '0;

    // Handshakes seen at the last rising edge, for the falling-edge drivers.
    logic           frame_taken = 1'b0;
    logic           cfg_taken = 1'b0;

    // Current register contents as the predictor sees them.
    logic [7:0]     cur_adjust [0:2] = '{8'd128, 8'd128, 8'd128};
    logic [31:0]    cur_accel_gain = 32'd262144;
    logic [31:0]    cur_gyro_gain  = 32'd32786009;
    logic [31:0]    cur_mag_gain   = 32'd2516582;

    logic [143:0]   pending_frames [$];
    logic [319:0]   expected_results [$];

    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             frames_accepted = 0;
    int             results_checked = 0;
    int             settings_loaded = 1;
    int             mismatches = 0;
    int             cycle_count = 0;

    string field_names [0:9] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y",
                                 "gyro_z", "mag_x", "mag_y", "mag_z", "heading"};

    imu_sample_scaling_and_heading_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Drop 16 fraction bits (floor) and clamp to the signed 32-bit range.
    function automatic longint sat_q16(input longint prod);
        longint v;
        v = prod >>> 16;
        if (v > SAT_HI)
            v = SAT_HI;
        else if (v < SAT_LO)
            v = SAT_LO;
        return v;
    endfunction

    // Vectoring CORDIC on (mag_y, mag_x); the angle runs in Q8.24 degrees.
    function automatic logic [24:0] compass_heading(input longint mx, input longint my);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint q;
        int     steps;
        x = my;
        y = mx;
        z = 0;
        steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
        if (x == 0 && y == 0)
            return 25'd0;
        // Left half plane: rotate by a half turn first.
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(180) << 24;
        end
        for (int i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q24[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q24[i];
            end
        end
        q = (z + 128) >>> 8;
        if (q < 0)
            q = q + (longint'(360) << 16);
        if (q >= (longint'(360) << 16))
            q = q - (longint'(360) << 16);
        return q[24:0];
    endfunction

    // Expected result word for one input frame under the current registers.
    function automatic logic [319:0] scale_frame(input logic [143:0] frame);
        logic [319:0] word;
        logic [47:0]  mb;
        logic [15:0]  raw [0:8];
        longint       scaled [0:8];
        word = '0;
        mb = frame[143:96];
        for (int k = 0; k < 3; k++)
        begin
            raw[k]     = frame[47 - 16*k -: 16];
            raw[3 + k] = frame[95 - 16*k -: 16];
            // Magnetometer pairs arrive low byte first.
            raw[6 + k] = {mb[39 - 16*k -: 8], mb[47 - 16*k -: 8]};
        end
        for (int k = 0; k < 9; k++)
        begin
            if (k < 3)
                scaled[k] = sat_q16(longint'($signed(raw[k]))
                                    * longint'({32'd0, cur_accel_gain}));
            else if (k < 6)
                scaled[k] = sat_q16(longint'($signed(raw[k]))
                                    * longint'({32'd0, cur_gyro_gain}));
            else
                scaled[k] = sat_q16(longint'($signed(raw[k]))
                                    * (longint'(cur_adjust[k - 6]) + 128)
                                    * longint'({32'd0, cur_mag_gain}));
            word[32*k +: 32] = scaled[k][31:0];
        end
        word[288 +: 25] = compass_heading(scaled[6], scaled[7]);
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [143:0] pack_frame(
        input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
        input logic [15:0] gx, input logic [15:0] gy, input logic [15:0] gz,
        input logic [15:0] mx, input logic [15:0] my, input logic [15:0] mz);
        return {mx[7:0], mx[15:8], my[7:0], my[15:8], mz[7:0], mz[15:8],
                gx, gy, gz, ax, ay, az};
    endfunction

    // Axis value biased toward the range ends and toward tiny magnitudes.
    function automatic logic [15:0] random_axis();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] random_frame();
        logic [15:0] v [0:8];
        for (int k = 0; k < 9; k++)
            v[k] = random_axis();
        // Now and then a frame with no horizontal field at all.
        if ($urandom_range(19) == 0)
        begin
            v[6] = 16'h0000;
            v[7] = 16'h0000;
        end
        return pack_frame(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    task automatic queue_corner_frames();
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_frames.push_back(pack_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        pending_frames.push_back(pack_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_frames.push_back(pack_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_frames.push_back(pack_frame(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                                 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001));
        pending_frames.push_back(pack_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        pending_frames.push_back(pack_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        // Headings on the four compass points.
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'd0, 16'd1000, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'd1000, 16'd0, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'd0, -16'sd1000, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, -16'sd1000, 16'd0, '0));
        // Just west and just east of north, where the wrap at 360 degrees sits.
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'hFFFF, 16'h7FFF, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'h0001, 16'h7FFF, '0));
        // No horizontal field, only vertical: heading must be zero.
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'd0, 16'd0, 16'h7FFF));
        // Southern half plane in each quadrant.
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, -16'sd5, -16'sd5, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'd5, -16'sd5, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'h8000, 16'h8000, '0));
        pending_frames.push_back(pack_frame('0, '0, '0, '0, '0, '0, 16'h7FFF, 16'h8000, '0));
    endtask

    // One register write; the local copy follows at the handshake.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(negedge clk);
        while (!cfg_taken);
        case (idx)
            REG_MAG_ADJ_X:  cur_adjust[0] = value[7:0];
            REG_MAG_ADJ_Y:  cur_adjust[1] = value[7:0];
            REG_MAG_ADJ_Z:  cur_adjust[2] = value[7:0];
            REG_ACCEL_GAIN: cur_accel_gain = value;
            REG_GYRO_GAIN:  cur_gyro_gain = value;
            REG_MAG_GAIN:   cur_mag_gain = value;
            default: ;
        endcase
        cfg_valid = 1'b0;
    endtask

    // Writes all six registers; byte registers get junk in their upper bits.
    task automatic load_settings(input logic [7:0] adj_x, input logic [7:0] adj_y,
                                 input logic [7:0] adj_z, input logic [31:0] accel_g,
                                 input logic [31:0] gyro_g, input logic [31:0] mag_g);
        write_register(REG_MAG_ADJ_X, {24'($urandom), adj_x});
        write_register(REG_MAG_ADJ_Y, {24'($urandom), adj_y});
        write_register(REG_MAG_ADJ_Z, {24'($urandom), adj_z});
        write_register(REG_ACCEL_GAIN, accel_g);
        write_register(REG_GYRO_GAIN, gyro_g);
        write_register(REG_MAG_GAIN, mag_g);
        settings_loaded++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH result %0d %s: got %h, want %h",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input logic [319:0] got);
        logic [319:0] want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result word with no frame outstanding", got[31:0], '0);
            return;
        end
        want = expected_results.pop_front();
        for (int f = 0; f < 9; f++)
            if (got[32*f +: 32] !== want[32*f +: 32])
                report_mismatch(field_names[f], got[32*f +: 32], want[32*f +: 32]);
        if (got[288 +: 25] !== want[288 +: 25])
            report_mismatch(field_names[9], 32'(got[288 +: 25]), 32'(want[288 +: 25]));
        if (got[313 +: 7] !== 7'd0)
            report_mismatch("padding", 32'(got[313 +: 7]), '0);
        results_checked++;
    endtask

    // ------------------------------------------------------------------
    // Driver, sink and monitor
    // ------------------------------------------------------------------

    // Source side: hold a word until it is taken, then maybe idle.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || frame_taken))
        begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tdata  <= pending_frames.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_taken <= 1'b0;
            cfg_taken   <= 1'b0;
        end
        else
        begin
            frame_taken <= s_tvalid && s_tready;
            cfg_taken   <= cfg_valid && cfg_ready;
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(scale_frame(s_tdata));
                frames_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Flow pattern rotates: free, source gaps, sink stalls, both.
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase

            case (p)
                0: ;  // Registers as left by reset.
                1: load_settings(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF);
                2: load_settings(8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0);
                3:
                begin
                    load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                  $urandom, $urandom, $urandom);
                    write_register(REG_SPARE_6, $urandom);
                    write_register(REG_SPARE_7, $urandom);
                end
                4: load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                 $urandom_range(1 << 20, 1), $urandom_range(1 << 26, 1),
                                 $urandom_range(1 << 24, 1));
                5: load_settings(8'h00, 8'hFF, 8'h80, $urandom_range(1 << 22),
                                 $urandom, $urandom_range(1 << 23));
                6: load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                 $urandom, $urandom_range(1 << 25), $urandom_range(1 << 22));
                default:
                begin
                    write_register(REG_SPARE_6, $urandom);
                    load_settings(8'hFF, 8'h00, 8'($urandom), $urandom,
                                  $urandom, $urandom_range(1 << 24));
                    write_register(REG_SPARE_7, $urandom);
                end
            endcase

            if (p == 0)
                queue_corner_frames();
            for (int n = 0; n < RANDOM_FRAMES; n++)
                pending_frames.push_back(random_frame());

            // Drain completely before the next register change.
            while (pending_frames.size() != 0 || s_tvalid || expected_results.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        $display("Sent %0d frames across %0d register settings and four flow patterns.",
                 frames_accepted, settings_loaded);
        $display("Compared %0d result words, %0d field mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
src/imush_pkg.sv
src/imush_scale_lane.sv
src/imush_cordic.sv
src/imu_sample_scaling_and_heading_top.sv
sim/imu_sample_scaling_and_heading_top_tb.sv
